/* design/gpad_pkg.sv */
// gpad_pkg: shared types and constants for the gamepad poll front end.
// No dependencies; used by the top level and its checker.
package gpad_pkg;

	localparam int AXIS_COUNT = 6;
	localparam int QUOT_BITS  = 15;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 152;

	// Configuration register indexes
	localparam logic [1:0] CFG_TRIG_THR = 2'd0;
	localparam logic [1:0] CFG_LEFT_DZ  = 2'd1;
	localparam logic [1:0] CFG_RIGHT_DZ = 2'd2;

	localparam logic [7:0]  TRIG_THR_RST = 8'd30;
	localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
	localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;

	// Full scale of the raw readings
	localparam logic [14:0] TRIG_FULL  = 15'd255;
	localparam logic [14:0] STICK_FULL = 15'd32767;

	// 1.0 in the output fixed point format
	localparam logic [15:0] ONE_FIX = 16'h8000;

	typedef logic signed [16:0] axis_val_t;

endpackage

/* design/gamepad_button_edge_and_axis_deadzone.sv */
// gamepad_button_edge_and_axis_deadzone: top level of the gamepad poll front end.
// Depends on gpad_pkg; one bit-serial restoring divider shared by all six axes.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-------------------------------
//  s_*       | in        | s_tvalid / s_tready   | one poll: s_tuser, s_tdata
//  m_*       | out       | m_tvalid / m_tready   | one result: m_tuser, m_tdata
//  cfg_*     | in        | cfg_valid / cfg_ready | register index, write data
//
// A successful poll passes each of the six axes through the engine and then loads
// the output register once it is free: each axis spends a step on the dead band and
// divisor, then the divider (one quotient bit per cycle), then one step to store.
// An axis that needs no division (zero or full scale) skips the divider.
// A failed poll goes straight to the output register, skipping the axis work.
// The result register is separate from the engine: the next poll is taken
// as soon as the engine is free, even while a result beat is stalled.
// Reset (arst_n low) restores register defaults and clears all held state.
// cfg_ready is always high; writes are only legal while the block is idle.
module gamepad_button_edge_and_axis_deadzone #(
	parameter int BUTTON_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// poll input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// bits 0: read_ok
	input  logic                            s_tuser,
	// low to high: button_bits[15:0], left_trigger_raw[7:0],
	// right_trigger_raw[7:0], left_x_raw, left_y_raw, right_x_raw, right_y_raw
	input  logic [gpad_pkg::S_TDATA_W-1:0]  s_tdata,
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// bits 0: connected
	output logic                            m_tuser,
	// low to high: button_levels, rising_edges, falling_edges (16 each),
	// left_trigger_value, right_trigger_value (16 each), left_x_value,
	// left_y_value, right_x_value, right_y_value (17 each), 4 zero pad bits
	output logic [gpad_pkg::M_TDATA_W-1:0]  m_tdata,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [14:0]                     cfg_data
);
	import gpad_pkg::*;

	localparam logic [15:0] BTN_MASK = 16'((17'd1 << BUTTON_COUNT) - 17'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_STORE,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0]  trig_thr_q;
	logic [14:0] left_dz_q;
	logic [14:0] right_dz_q;

	// held state
	logic        conn_q;
	logic [15:0] prev_btn_q;
	logic [15:0] rise_q;
	logic [15:0] fall_q;
	axis_val_t   held_q [AXIS_COUNT];

	// axis engine
	logic [15:0] raw_q [AXIS_COUNT];
	logic [2:0]  axis_cnt_q;
	logic [3:0]  bit_cnt_q;
	logic [14:0] rem_q;
	logic [14:0] dvsr_q;
	logic [15:0] quot_q;
	logic        neg_q;

	// output register
	logic                   m_tvalid_q;
	logic                   m_tuser_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	logic        in_fire;
	logic        out_free;
	logic [15:0] btn_now;

	// setup stage signals
	logic        is_trig;
	logic [14:0] zone;
	logic [14:0] full;
	logic [15:0] raw;
	logic        neg;
	logic [15:0] mag;
	logic [15:0] num;
	logic [14:0] dvsr;

	// divider step
	logic [15:0] rem_x2;
	logic        rem_ge;
	logic [14:0] rem_nxt;

	axis_val_t   axis_res;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign btn_now   = s_tdata[15:0] & BTN_MASK;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// Dead band and divisor for the axis at the head of the raw shift line.
	// Axes 0-1 are triggers, 2-3 left stick, 4-5 right stick.
	always_comb begin
		is_trig = (axis_cnt_q < 3'd2);
		if (is_trig) begin
			zone = {7'd0, trig_thr_q};
			full = TRIG_FULL;
		end else if (axis_cnt_q < 3'd4) begin
			zone = left_dz_q;
			full = STICK_FULL;
		end else begin
			zone = right_dz_q;
			full = STICK_FULL;
		end
		raw = raw_q[0];
		neg = !is_trig && raw[15];
		// -32768 maps to a magnitude of 32768
		mag = neg ? 16'(17'h10000 - {1'b0, raw}) : raw;
		num = (mag > {1'b0, zone}) ? (mag - {1'b0, zone}) : 16'd0;
		dvsr = (full > zone) ? (full - zone) : 15'd0;
	end

	// One restoring step: remainder stays below the divisor
	always_comb begin
		rem_x2  = {rem_q, 1'b0};
		rem_ge  = (rem_x2 >= {1'b0, dvsr_q});
		rem_nxt = rem_ge ? 15'(rem_x2 - {1'b0, dvsr_q}) : rem_x2[14:0];
	end

	assign axis_res = neg_q ? axis_val_t'(17'd0 - {1'b0, quot_q})
	                        : axis_val_t'({1'b0, quot_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_thr_q <= TRIG_THR_RST;
			left_dz_q  <= LEFT_DZ_RST;
			right_dz_q <= RIGHT_DZ_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TRIG_THR: trig_thr_q <= cfg_data[7:0];
				CFG_LEFT_DZ:  left_dz_q  <= cfg_data;
				CFG_RIGHT_DZ: right_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// engine datapath (no reset needed)
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					raw_q[0] <= {8'd0, s_tdata[23:16]};
					raw_q[1] <= {8'd0, s_tdata[31:24]};
					raw_q[2] <= s_tdata[47:32];
					raw_q[3] <= s_tdata[63:48];
					raw_q[4] <= s_tdata[79:64];
					raw_q[5] <= s_tdata[95:80];
				end
			end
			ST_SETUP: begin
				neg_q  <= neg;
				dvsr_q <= dvsr;
				rem_q  <= num[14:0];
				if (num == 16'd0) begin
					quot_q <= 16'd0;
				end else if (num >= {1'b0, dvsr}) begin
					// at or past full scale, including a zero divisor
					quot_q <= ONE_FIX;
				end else begin
					quot_q <= 16'd0;
				end
			end
			ST_DIV: begin
				rem_q  <= rem_nxt;
				quot_q <= {quot_q[14:0], rem_ge};
			end
			ST_STORE: begin
				for (int i = 0; i < AXIS_COUNT - 1; i++) begin
					raw_q[i] <= raw_q[i+1];
				end
				raw_q[AXIS_COUNT-1] <= raw_q[0];
			end
			default: ;
		endcase
	end

	// control, held state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_cnt_q <= '0;
			bit_cnt_q  <= '0;
			conn_q     <= 1'b0;
			prev_btn_q <= '0;
			rise_q     <= '0;
			fall_q     <= '0;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				held_q[i] <= '0;
			end
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// ST_OUT reloads the register itself whenever the beat leaves
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						axis_cnt_q <= '0;
						if (s_tuser) begin
							conn_q     <= 1'b1;
							rise_q     <= (btn_now ^ prev_btn_q) & btn_now;
							fall_q     <= (btn_now ^ prev_btn_q) & prev_btn_q;
							prev_btn_q <= btn_now;
							state_q    <= ST_SETUP;
						end else begin
							conn_q  <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_SETUP: begin
					bit_cnt_q <= '0;
					if (num != 16'd0 && num < {1'b0, dvsr}) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + 4'd1;
					if (bit_cnt_q == 4'(QUOT_BITS - 1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					for (int i = 0; i < AXIS_COUNT - 1; i++) begin
						held_q[i] <= held_q[i+1];
					end
					held_q[AXIS_COUNT-1] <= axis_res;
					axis_cnt_q <= axis_cnt_q + 3'd1;
					if (axis_cnt_q == 3'(AXIS_COUNT - 1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= conn_q;
						m_tdata_q  <= {4'd0, held_q[5], held_q[4], held_q[3], held_q[2],
						               held_q[1][15:0], held_q[0][15:0],
						               fall_q, rise_q, prev_btn_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/gpad_chk.sv */
// gpad_chk: port-level checks for the gamepad poll front end, bound to the top.
// Depends on gpad_pkg and gamepad_button_edge_and_axis_deadzone.
module gpad_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic                            m_tuser,
	input logic [gpad_pkg::M_TDATA_W-1:0]  m_tdata
);
	import gpad_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one poll at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("poll taken while engine busy");

	// a button cannot rise and fall at once
	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[31:16] & m_tdata[47:32]) == 16'd0))
		else $error("rising and falling edge on the same button");

	// rising edges only on pressed buttons, falling only on released ones
	a_edges_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[31:16] & ~m_tdata[15:0]) == 16'd0)
		          && ((m_tdata[47:32] & m_tdata[15:0]) == 16'd0))
		else $error("edge flag disagrees with button level");

	// triggers never exceed full scale
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:48] <= ONE_FIX) && (m_tdata[79:64] <= ONE_FIX))
		else $error("trigger value above 1.0");

endmodule

bind gamepad_button_edge_and_axis_deadzone gpad_chk u_gpad_chk (.*);
